>>> rtl/oaids_pkg.sv
package oaids_pkg;

  // List geometry
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int CMP_W    = POS_W + 1;
  localparam int DATA_W   = 32;

  typedef logic [DATA_W-1:0] data_t;

  // Operation codes
  localparam logic [2:0] OP_APPEND  = 3'd0;
  localparam logic [2:0] OP_DISPLAY = 3'd1;
  localparam logic [2:0] OP_INSERT  = 3'd2;
  localparam logic [2:0] OP_DELETE  = 3'd3;
  localparam logic [2:0] OP_SEARCH  = 3'd4;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BADPOS   = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  // What a cell loads this cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LEFT,
    CELL_RIGHT,
    CELL_NEW,
    CELL_FIRST
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     cmp_load;
    logic     cmp_en;
  } cell_ctrl_t;

endpackage

>>> rtl/oaids_cell.sv
module oaids_cell
  import oaids_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  data_t      left,
  input  data_t      right,
  input  data_t      first,
  input  data_t      new_value,
  input  data_t      key,
  output data_t      value,
  output logic       match
);

  // Element storage: shift, load or hold
  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_HOLD:  value <= value;
      CELL_LEFT:  value <= left;
      CELL_RIGHT: value <= right;
      CELL_NEW:   value <= new_value;
      CELL_FIRST: value <= first;
      default:    value <= value;
    endcase
  end

  // Search compare, only for occupied cells
  always_ff @(posedge clk) begin
    if (ctrl.cmp_load) begin
      match <= ctrl.cmp_en && (value == key);
    end
  end

endmodule

>>> rtl/ordered_array_insert_delete_search_top.sv
// Ordered list of up to CAPACITY signed 32-bit values held in a chain of cells,
// one value per cell. Append, insert and delete update every cell at once: each
// cell loads its neighbor or the new value. Search: all cells compare in
// parallel into match flags, then a priority encoder picks the first hit.
// Display rotates the occupied cells through cell 0 and sends one element per
// cycle while the receiver is ready. One request is worked at a time; every
// result passes through a single output register, which is what limits the
// display stream to one element per cycle. Operation codes 5 to 7 are dropped
// without a result.
module ordered_array_insert_delete_search_top
  import oaids_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          operation,
  input  logic [POS_W-1:0]    position,
  input  logic signed [31:0]  item_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          status,
  output logic [POS_W-1:0]    found_position,
  output logic signed [31:0]  element_value,
  output logic                last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_DISP = 2'd2;

  logic [1:0]          state, state_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [CNT_W-1:0]    disp_idx, disp_idx_next;
  data_t               key;
  cell_ctrl_t          cell_ctrl [CAPACITY];
  data_t               cell_value [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic                out_free, acc;
  logic                out_load;
  logic [2:0]          status_next;
  logic [POS_W-1:0]    pos_next;
  data_t               value_next;
  logic                last_next;
  logic [IDX_W-1:0]    hit_idx;
  logic                hit;
  logic [CMP_W-1:0]    n8, p8;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign acc      = in_valid && in_ready;
  assign n8       = CMP_W'(count);
  assign p8       = CMP_W'(position);

  // Cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    data_t left_v, right_v;
    if (g == 0) begin : g_first
      assign left_v = cell_value[0];
    end else begin : g_mid
      assign left_v = cell_value[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right_v = cell_value[g];
    end else begin : g_inner
      assign right_v = cell_value[g+1];
    end
    oaids_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[g]),
      .left      (left_v),
      .right     (right_v),
      .first     (cell_value[0]),
      .new_value (item_value),
      .key       (key),
      .value     (cell_value[g]),
      .match     (match[g])
    );
  end

  // First matching cell
  always_comb begin
    hit_idx = '0;
    hit     = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
        hit     = 1'b1;
      end
    end
  end

  // Request decode, cell control and result selection
  always_comb begin
    state_next    = state;
    count_next    = count;
    disp_idx_next = disp_idx;
    out_load      = 1'b0;
    status_next   = ST_OK;
    pos_next      = '0;
    value_next    = '0;
    last_next     = 1'b1;
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ctrl[i] = '{op: CELL_HOLD, cmp_load: 1'b0, cmp_en: 1'b0};
    end

    case (state)
      S_IDLE: begin
        if (acc) begin
          case (operation)
            OP_APPEND: begin
              out_load = 1'b1;
              if (n8 >= CMP_W'(CAPACITY)) begin
                status_next = ST_FULL;
              end else begin
                for (int i = 0; i < CAPACITY; i++) begin
                  if (CMP_W'(i) == n8) cell_ctrl[i].op = CELL_NEW;
                end
                count_next = count + CNT_W'(1);
              end
            end
            OP_DISPLAY: begin
              if (count == '0) begin
                out_load    = 1'b1;
                status_next = ST_EMPTY;
              end else begin
                state_next    = S_DISP;
                disp_idx_next = '0;
              end
            end
            OP_INSERT: begin
              out_load = 1'b1;
              if (p8 < CMP_W'(1) || p8 > n8 + CMP_W'(1)) begin
                status_next = ST_BADPOS;
              end else if (n8 >= CMP_W'(CAPACITY)) begin
                status_next = ST_FULL;
              end else begin
                for (int i = 0; i < CAPACITY; i++) begin
                  if (CMP_W'(i) + CMP_W'(1) == p8) begin
                    cell_ctrl[i].op = CELL_NEW;
                  end else if (CMP_W'(i) + CMP_W'(1) > p8 && CMP_W'(i) <= n8) begin
                    cell_ctrl[i].op = CELL_LEFT;
                  end
                end
                count_next = count + CNT_W'(1);
              end
            end
            OP_DELETE: begin
              out_load = 1'b1;
              if (p8 < CMP_W'(1) || p8 > n8) begin
                status_next = ST_BADPOS;
              end else begin
                for (int i = 0; i < CAPACITY; i++) begin
                  if (CMP_W'(i) + CMP_W'(1) >= p8 && CMP_W'(i) + CMP_W'(2) <= n8) begin
                    cell_ctrl[i].op = CELL_RIGHT;
                  end
                end
                count_next = count - CNT_W'(1);
              end
            end
            OP_SEARCH: begin
              for (int i = 0; i < CAPACITY; i++) begin
                cell_ctrl[i].cmp_load = 1'b1;
                cell_ctrl[i].cmp_en   = CMP_W'(i) < n8;
              end
              state_next = S_SRCH;
            end
            default: begin
            end
          endcase
        end
      end

      S_SRCH: begin
        if (out_free) begin
          out_load = 1'b1;
          if (hit) begin
            pos_next = POS_W'(hit_idx) + POS_W'(1);
          end else begin
            status_next = ST_NOTFOUND;
          end
          state_next = S_IDLE;
        end
      end

      S_DISP: begin
        if (out_free) begin
          out_load   = 1'b1;
          pos_next   = POS_W'(disp_idx) + POS_W'(1);
          value_next = cell_value[0];
          last_next  = (disp_idx + CNT_W'(1)) == count;
          // rotate the occupied cells by one place
          for (int i = 0; i < CAPACITY; i++) begin
            if (CMP_W'(i) + CMP_W'(1) < n8) begin
              cell_ctrl[i].op = CELL_RIGHT;
            end else if (CMP_W'(i) + CMP_W'(1) == n8) begin
              cell_ctrl[i].op = CELL_FIRST;
            end
          end
          disp_idx_next = disp_idx + CNT_W'(1);
          if (last_next) state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      disp_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      disp_idx <= disp_idx_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      status         <= status_next;
      found_position <= pos_next;
      element_value  <= value_next;
      last           <= last_next;
    end
  end

  // key is the request value, used directly by the cells
  assign key = item_value;

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(count) <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_count_on_req: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(count)) |-> $past(acc))
    else $error("element count changed without a request");

  a_pos_in_list: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OK && found_position != '0)
      |-> (CMP_W'(found_position) <= n8))
    else $error("reported position beyond the list");

  a_disp_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_DISP) |-> (count != '0 && !in_ready))
    else $error("display running on empty list or accepting requests");
`endif

endmodule

>>> test/oaids_list_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the ordered list block, keeps a shadow copy of
// the list and checks every result against the expected one.
module oaids_list_checker
  import oaids_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [2:0]          operation,
  input  logic [POS_W-1:0]    position,
  input  logic signed [31:0]  item_value,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [2:0]          status,
  input  logic [POS_W-1:0]    found_position,
  input  logic signed [31:0]  element_value,
  input  logic                last,
  output int                  mismatch_count,
  output int                  results_owed,
  output int                  list_size
);

  typedef struct {
    logic [2:0]       status;
    logic [POS_W-1:0] position;
    data_t            value;
    logic             last;
  } list_result_t;

  list_result_t owed_q[$];
  data_t        shadow_list [CAPACITY];
  int           shadow_len;
  int           errors;

  task automatic owe_result(input logic [2:0] st, input int pos, input data_t v,
                            input logic lst);
    list_result_t r;
    r.status   = st;
    r.position = POS_W'(pos);
    r.value    = v;
    r.last     = lst;
    owed_q.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Apply one request to the shadow list and queue what it should produce
  task automatic run_request(input logic [2:0] op, input logic [POS_W-1:0] pos_in,
                             input data_t v);
    int pos;
    int hit;
    pos = int'(pos_in);
    hit = 0;
    case (op)
      OP_APPEND: begin
        if (shadow_len >= CAPACITY) begin
          owe_result(ST_FULL, 0, '0, 1'b1);
        end else begin
          shadow_list[shadow_len] = v;
          shadow_len++;
          owe_result(ST_OK, 0, '0, 1'b1);
        end
      end
      OP_DISPLAY: begin
        if (shadow_len == 0) begin
          owe_result(ST_EMPTY, 0, '0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_len; i++)
            owe_result(ST_OK, i + 1, shadow_list[i], 1'(i == shadow_len - 1));
        end
      end
      OP_INSERT: begin
        if (pos < 1 || pos > shadow_len + 1) begin
          owe_result(ST_BADPOS, 0, '0, 1'b1);
        end else if (shadow_len >= CAPACITY) begin
          owe_result(ST_FULL, 0, '0, 1'b1);
        end else begin
          // open a slot at pos by moving the tail up
          for (int i = shadow_len; i >= pos; i--)
            shadow_list[i] = shadow_list[i-1];
          shadow_list[pos-1] = v;
          shadow_len++;
          owe_result(ST_OK, 0, '0, 1'b1);
        end
      end
      OP_DELETE: begin
        if (pos < 1 || pos > shadow_len) begin
          owe_result(ST_BADPOS, 0, '0, 1'b1);
        end else begin
          for (int i = pos - 1; i < shadow_len - 1; i++)
            shadow_list[i] = shadow_list[i+1];
          shadow_len--;
          owe_result(ST_OK, 0, '0, 1'b1);
        end
      end
      OP_SEARCH: begin
        // first match wins
        for (int i = 0; i < shadow_len; i++)
          if (hit == 0 && shadow_list[i] == v) hit = i + 1;
        if (hit != 0) owe_result(ST_OK, hit, '0, 1'b1);
        else owe_result(ST_NOTFOUND, 0, '0, 1'b1);
      end
      default: ; // unused codes are dropped
    endcase
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      shadow_len = 0;
      owed_q.delete();
    end else begin
      // compare the result leaving the block
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none actual status %0d pos %0d value %0h last %0b",
                   $time, status, found_position, element_value, last);
        end else begin
          want = owed_q.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("found_position", 32'(want.position), 32'(found_position));
          check_field("element_value", want.value, element_value);
          check_field("last", 32'(want.last), 32'(last));
        end
      end
      // predict the request entering the block
      if (in_valid && in_ready) run_request(operation, position, item_value);
    end
    mismatch_count <= errors;
    results_owed   <= owed_q.size();
    list_size      <= shadow_len;
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
  import oaids_pkg::*;

  localparam int          RANDOM_ITEMS  = 410;
  localparam int          STALL_LIMIT   = 2000;
  localparam logic [2:0]  OP_RSVD_FIRST = 3'd5;
  localparam logic [2:0]  OP_RSVD_LAST  = 3'd7;
  localparam data_t       INT_MIN_VAL   = 32'h8000_0000;
  localparam data_t       INT_MAX_VAL   = 32'h7FFF_FFFF;

  typedef enum int { MIX_GROW, MIX_SHRINK, MIX_BALANCED } mix_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [2:0]          operation = OP_APPEND;
  logic [POS_W-1:0]    position = '0;
  logic signed [31:0]  item_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [2:0]          status;
  logic [POS_W-1:0]    found_position;
  logic signed [31:0]  element_value;
  logic                last;

  int    mismatch_count;
  int    results_owed;
  int    list_size;
  int    send_idle_pct = 15;
  int    recv_idle_pct = 64;
  int    items_sent = 0;
  int    stall_cycles = 0;
  data_t value_pool [8];

  ordered_array_insert_delete_search_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .position       (position),
    .item_value     (item_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .found_position (found_position),
    .element_value  (element_value),
    .last           (last)
  );

  oaids_list_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .position       (position),
    .item_value     (item_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .found_position (found_position),
    .element_value  (element_value),
    .last           (last),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed),
    .list_size      (list_size)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog: too long without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one request; valid stays up into the next one unless a gap is drawn
  task automatic send_item(input logic [2:0] op, input int pos, input data_t val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    position   <= POS_W'(pos);
    item_value <= val;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // mostly values from a small pool so searches hit and duplicates occur
  function automatic data_t pick_value();
    if ($urandom_range(9) < 6) return value_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  task automatic random_request(input mix_t mix);
    int          w [6];
    int          roll;
    int          acc;
    int          slot;
    int          n;
    int          pos;
    logic [2:0]  op;
    // weights: append, display, insert, delete, search, unused code
    case (mix)
      MIX_GROW:   w = '{40, 4, 35, 8, 10, 3};
      MIX_SHRINK: w = '{10, 5, 10, 55, 17, 3};
      default:    w = '{20, 8, 22, 22, 25, 3};
    endcase
    roll = $urandom_range(99);
    acc  = 0;
    slot = -1;
    for (int k = 0; k < 6; k++) begin
      acc += w[k];
      if (slot < 0 && roll < acc) slot = k;
    end
    case (slot)
      0:       op = OP_APPEND;
      1:       op = OP_DISPLAY;
      2:       op = OP_INSERT;
      3:       op = OP_DELETE;
      4:       op = OP_SEARCH;
      default: op = 3'(OP_RSVD_FIRST + $urandom_range(OP_RSVD_LAST - OP_RSVD_FIRST));
    endcase
    n   = list_size;
    pos = $urandom_range(0, CAPACITY + 1);
    // insert and delete mostly land on a legal position
    if (op == OP_INSERT && $urandom_range(9) != 0) pos = $urandom_range(1, n + 1);
    if (op == OP_DELETE && n > 0 && $urandom_range(9) != 0) pos = $urandom_range(1, n);
    send_item(op, pos, pick_value());
  endtask

  // grow to capacity, then poke at the full list
  task automatic fill_list();
    while (list_size < CAPACITY) begin
      if ($urandom_range(1)) send_item(OP_APPEND, $urandom_range(0, CAPACITY + 1), pick_value());
      else send_item(OP_INSERT, $urandom_range(1, list_size + 1), pick_value());
    end
    send_item(OP_APPEND, 0, pick_value());
    send_item(OP_INSERT, $urandom_range(1, CAPACITY + 1), pick_value());
    send_item(OP_INSERT, CAPACITY + 1, pick_value());
    send_item(OP_DISPLAY, 0, pick_value());
    send_item(OP_SEARCH, 0, pick_value());
  endtask

  // delete down to empty, then poke at the empty list
  task automatic drain_list();
    while (list_size > 0)
      send_item(OP_DELETE, $urandom_range(1, list_size), pick_value());
    send_item(OP_DISPLAY, 0, pick_value());
    send_item(OP_DELETE, 1, pick_value());
    send_item(OP_SEARCH, 0, pick_value());
  endtask

  initial begin
    int chunk;
    int roll;
    value_pool[0] = INT_MIN_VAL;
    value_pool[1] = INT_MAX_VAL;
    value_pool[2] = '0;
    value_pool[3] = '1;
    for (int k = 4; k < 8; k++) value_pool[k] = $urandom;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, bad positions, extremes, duplicates, unused codes
    send_item(OP_DISPLAY, 0, '0);
    send_item(OP_DELETE, 1, '0);
    send_item(OP_SEARCH, 0, '0);
    send_item(OP_INSERT, 0, 32'h1111_1111);
    send_item(OP_INSERT, 2, 32'h2222_2222);
    send_item(OP_INSERT, 1, INT_MAX_VAL);
    send_item(OP_APPEND, CAPACITY + 1, INT_MIN_VAL);
    send_item(OP_APPEND, 0, '0);
    send_item(OP_APPEND, 0, '1);
    send_item(OP_INSERT, 5, 32'h5A5A_5A5A);
    send_item(OP_INSERT, 1, '1);
    send_item(OP_SEARCH, 0, '1);
    send_item(OP_SEARCH, 0, 32'h0000_3039);
    send_item(OP_DISPLAY, CAPACITY, '0);
    send_item(OP_DELETE, 0, '0);
    send_item(OP_DELETE, 7, '0);
    send_item(OP_DELETE, 6, '0);
    send_item(OP_DELETE, 1, '0);
    send_item(OP_DELETE, 2, '0);
    send_item(OP_INSERT, CAPACITY + 1, 32'hA5A5_A5A5);
    send_item(OP_RSVD_FIRST, 1, '1);
    send_item(OP_RSVD_LAST, 1, '1);
    send_item(OP_SEARCH, 0, INT_MIN_VAL);
    send_item(OP_DISPLAY, 0, '0);

    // random: mixes of traffic with occasional fill-to-full and drain-to-empty
    chunk = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 15;
        recv_idle_pct = 64;
      end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 64;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      roll = $urandom_range(9);
      if (chunk == 1 || roll == 0) begin
        fill_list();
      end else if (chunk == 3 || roll == 1) begin
        drain_list();
      end else begin
        repeat (16) random_request(mix_t'($urandom_range(2)));
      end
      chunk++;
    end
    in_valid <= 1'b0;

    // let the block finish what it owes
    do @(posedge clk); while (results_owed != 0);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
